@@ rtl/imdp_pkg.sv @@
`default_nettype none
package imdp_pkg;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_MASK     = 2'd0;
  localparam cmd_t CMD_UNMASK   = 2'd1;
  localparam cmd_t CMD_DISPATCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP
  } state_t;

  localparam logic [31:0] SRC_VALID   = 32'hFFFF_FFE0;
  localparam logic [31:0] GM_RESET    = 32'hFFFF_FFE0;
  localparam logic [13:0] PI_EN_RESET = 14'h00F0;

  localparam logic [2:0] GRP_MEM  = 3'd0;
  localparam logic [2:0] GRP_DSP  = 3'd1;
  localparam logic [2:0] GRP_AI   = 3'd2;
  localparam logic [2:0] GRP_EXI0 = 3'd3;
  localparam logic [2:0] GRP_EXI1 = 3'd4;
  localparam logic [2:0] GRP_EXI2 = 3'd5;
  localparam logic [2:0] GRP_PI   = 3'd6;
  localparam logic [2:0] GRP_NONE = 3'd7;

  localparam logic [3:0] PRIO_LAST = 4'd10;

  typedef struct packed {
    logic       load;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       grp_emit;
    logic       none_emit;
    logic       disp_emit;
    logic [3:0] cnt;
  } ctrl_t;

  typedef struct packed {
    logic slot_free;
    logic grp_hit;
    logic grp_last;
    logic chg_zero;
    logic disp_hit;
  } stat_t;

  typedef struct packed {
    logic [15:0] fm;
    logic [15:0] fv;
  } field_t;

  // source bits of each group
  function automatic logic [31:0] group_bits(input logic [2:0] g);
    logic [31:0] r;
    unique case (g)
      GRP_MEM:  r = 32'hF800_0000;
      GRP_DSP:  r = 32'h0700_0000;
      GRP_AI:   r = 32'h0080_0000;
      GRP_EXI0: r = 32'h0070_0000;
      GRP_EXI1: r = 32'h000E_0000;
      GRP_EXI2: r = 32'h0001_8000;
      GRP_PI:   r = 32'h0000_7FE0;
      default:  r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // source bits of all groups after g
  function automatic logic [31:0] rest_bits(input logic [2:0] g);
    logic [31:0] r;
    unique case (g)
      GRP_MEM:  r = 32'h07FF_FFE0;
      GRP_DSP:  r = 32'h00FF_FFE0;
      GRP_AI:   r = 32'h007F_FFE0;
      GRP_EXI0: r = 32'h000F_FFE0;
      GRP_EXI1: r = 32'h0001_FFE0;
      GRP_EXI2: r = 32'h0000_7FE0;
      default:  r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] prio_entry(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd0:    r = 32'h0000_0100;
      4'd1:    r = 32'h0000_0040;
      4'd2:    r = 32'hF800_0000;
      4'd3:    r = 32'h0000_0200;
      4'd4:    r = 32'h0000_0080;
      4'd5:    r = 32'h0000_3000;
      4'd6:    r = 32'h0000_0020;
      4'd7:    r = 32'h03FF_8C00;
      4'd8:    r = 32'h0400_0000;
      4'd9:    r = 32'h0000_4000;
      4'd10:   r = 32'hFFFF_FFFF;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // enable value when source i (bit 31 - i) is unmasked
  function automatic logic [15:0] en(input logic [31:0] cur, input int i,
                                     input logic [15:0] val);
    return cur[31 - i] ? 16'h0000 : val;
  endfunction

  function automatic field_t group_field(input logic [2:0] g, input logic [31:0] cur);
    field_t f;
    unique case (g)
      GRP_MEM: begin
        f.fv = en(cur, 0, 16'h01) | en(cur, 1, 16'h02) | en(cur, 2, 16'h04) |
               en(cur, 3, 16'h08) | en(cur, 4, 16'h10);
        f.fm = 16'hFFFF;
      end
      GRP_DSP: begin
        f.fv = en(cur, 5, 16'h10) | en(cur, 6, 16'h40) | en(cur, 7, 16'h100);
        f.fm = 16'h01F8;
      end
      GRP_AI: begin
        f.fv = en(cur, 8, 16'h04);
        f.fm = 16'h002C;
      end
      GRP_EXI0: begin
        f.fv = en(cur, 9, 16'h001) | en(cur, 10, 16'h004) | en(cur, 11, 16'h400);
        f.fm = 16'h2C0F;
      end
      GRP_EXI1: begin
        f.fv = en(cur, 12, 16'h001) | en(cur, 13, 16'h004) | en(cur, 14, 16'h400);
        f.fm = 16'h0C0F;
      end
      GRP_EXI2: begin
        f.fv = en(cur, 15, 16'h1) | en(cur, 16, 16'h4);
        f.fm = 16'h000F;
      end
      default: begin
        f.fv = 16'h00F0 | en(cur, 17, 16'h0800) | en(cur, 20, 16'h0008) |
               en(cur, 21, 16'h0004) | en(cur, 22, 16'h0002) |
               en(cur, 23, 16'h0001) | en(cur, 24, 16'h0100) |
               en(cur, 25, 16'h1000) | en(cur, 18, 16'h0200) |
               en(cur, 19, 16'h0400) | en(cur, 26, 16'h2000);
        f.fm = 16'hFFFF;
      end
    endcase
    return f;
  endfunction

  // lowest source index present in hit
  function automatic logic [4:0] first_src(input logic [31:0] hit);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 26; i >= 0; i--) begin
      if (hit[31 - i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

@@ rtl/imdp_ctrl.sv @@
`default_nettype none
module imdp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_cmd,
  output logic                 in_ready,
  input  wire imdp_pkg::stat_t stat,
  output imdp_pkg::ctrl_t      ctrl
);

  imdp_pkg::state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imdp_pkg::ST_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imdp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == imdp_pkg::CMD_MASK || in_cmd == imdp_pkg::CMD_UNMASK)
            state_nxt = imdp_pkg::ST_SCAN;
          else if (in_cmd == imdp_pkg::CMD_DISPATCH)
            state_nxt = imdp_pkg::ST_DISP;
        end
      end
      imdp_pkg::ST_SCAN: begin
        priority if (stat.chg_zero) begin
          if (stat.slot_free) state_nxt = imdp_pkg::ST_IDLE;
        end else if (stat.grp_hit) begin
          if (stat.slot_free && stat.grp_last) state_nxt = imdp_pkg::ST_IDLE;
        end else if (cnt_r[2:0] == imdp_pkg::GRP_PI) begin
          state_nxt = imdp_pkg::ST_IDLE;
        end
      end
      imdp_pkg::ST_DISP: begin
        if ((stat.disp_hit || cnt_r == imdp_pkg::PRIO_LAST) && stat.slot_free)
          state_nxt = imdp_pkg::ST_IDLE;
      end
      default: state_nxt = imdp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    ctrl           = '0;
    ctrl.cnt       = cnt_r;
    unique case (state_r)
      imdp_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.load    = in_valid;
        ctrl.cnt_clr = 1'b1;
      end
      imdp_pkg::ST_SCAN: begin
        priority if (stat.chg_zero) begin
          ctrl.none_emit = stat.slot_free;
        end else if (stat.grp_hit) begin
          ctrl.grp_emit = stat.slot_free;
          ctrl.cnt_inc  = stat.slot_free && !stat.grp_last;
        end else begin
          ctrl.cnt_inc = 1'b1;
        end
      end
      imdp_pkg::ST_DISP: begin
        if (stat.disp_hit || cnt_r == imdp_pkg::PRIO_LAST)
          ctrl.disp_emit = stat.slot_free;
        else
          ctrl.cnt_inc = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.cnt_clr)
      cnt_nxt = 4'd0;
    else if (ctrl.cnt_inc)
      cnt_nxt = cnt_r + 4'd1;
  end

endmodule
`default_nettype wire

@@ rtl/imdp_dpath.sv @@
`default_nettype none
module imdp_dpath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire imdp_pkg::ctrl_t  ctrl,
  output imdp_pkg::stat_t       stat,
  input  wire logic             cfg_valid,
  input  wire logic [31:0]      cfg_local_mask,
  input  wire logic [1:0]       in_cmd,
  input  wire logic [31:0]      in_mask_bits,
  input  wire logic [15:0]      in_pi_status,
  input  wire logic [4:0]       in_mem_status,
  input  wire logic [15:0]      in_dsp_status,
  input  wire logic [15:0]      in_ai_status,
  input  wire logic [15:0]      in_exi0_status,
  input  wire logic [15:0]      in_exi1_status,
  input  wire logic [15:0]      in_exi2_status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           out_prev_mask,
  output logic [2:0]            out_group,
  output logic [15:0]           out_field_mask,
  output logic [15:0]           out_field_value,
  output logic                  out_found,
  output logic [4:0]            out_irq_index,
  output logic                  out_is_peripheral,
  output logic                  out_last
);

  logic [31:0] lm_r;
  logic [31:0] gm_r, gm_nxt;
  logic [13:0] pi_en_r;
  logic [31:0] prev_r, chg_r, chg_nxt, unm_r;
  logic        out_valid_r;

  logic [31:0] m, comb_mask, cause, hit, cur;
  logic [15:0] st;
  logic        pending, emit;
  logic [2:0]  g;
  imdp_pkg::field_t fld;

  assign g         = ctrl.cnt[2:0];
  assign m         = in_mask_bits & imdp_pkg::SRC_VALID;
  assign comb_mask = gm_r | lm_r;
  assign cur       = gm_r | lm_r;
  assign fld       = imdp_pkg::group_field(g, cur);
  assign hit       = unm_r & imdp_pkg::prio_entry(ctrl.cnt);
  assign emit      = ctrl.grp_emit | ctrl.none_emit | ctrl.disp_emit;

  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.grp_hit   = (chg_r & imdp_pkg::group_bits(g)) != 32'd0;
  assign stat.grp_last  = (chg_r & imdp_pkg::rest_bits(g)) == 32'd0;
  assign stat.chg_zero  = chg_r == 32'd0;
  assign stat.disp_hit  = hit != 32'd0;

  // cause gathering; source i lands on bit 31 - i
  assign st      = in_pi_status;
  assign pending = (st != 16'd0) && ((st & {2'b00, pi_en_r}) != 16'd0);
  always_comb begin
    cause = 32'd0;
    if (st[7]) begin
      for (int i = 0; i < 5; i++) cause[31 - i] = in_mem_status[i];
    end
    if (st[6]) begin
      cause[26] = in_dsp_status[3];
      cause[25] = in_dsp_status[5];
      cause[24] = in_dsp_status[7];
    end
    cause[23] = st[5] & in_ai_status[3];
    if (st[4]) begin
      cause[22] = in_exi0_status[1];
      cause[21] = in_exi0_status[3];
      cause[20] = in_exi0_status[11];
      cause[19] = in_exi1_status[1];
      cause[18] = in_exi1_status[3];
      cause[17] = in_exi1_status[11];
      cause[16] = in_exi2_status[1];
      cause[15] = in_exi2_status[3];
    end
    cause[5]  = st[13];
    cause[6]  = st[12];
    cause[12] = st[10];
    cause[13] = st[9];
    cause[7]  = st[8];
    cause[11] = st[3];
    cause[10] = st[2];
    cause[9]  = st[1];
    cause[14] = st[11];
    cause[8]  = st[0];
  end

  always_comb begin
    gm_nxt  = gm_r;
    chg_nxt = ~comb_mask & m;
    if (in_cmd == imdp_pkg::CMD_MASK) begin
      gm_nxt  = gm_r | m;
      chg_nxt = ~comb_mask & m;
    end else if (in_cmd == imdp_pkg::CMD_UNMASK) begin
      gm_nxt  = gm_r & ~m;
      chg_nxt = comb_mask & m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lm_r        <= 32'd0;
      gm_r        <= imdp_pkg::GM_RESET;
      pi_en_r     <= imdp_pkg::PI_EN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) lm_r <= cfg_local_mask;
      if (ctrl.load) gm_r <= gm_nxt;
      if (ctrl.grp_emit && g == imdp_pkg::GRP_PI) pi_en_r <= fld.fv[13:0];
      if (emit)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prev_r <= gm_r;
      chg_r  <= chg_nxt;
      unm_r  <= pending ? (cause & ~comb_mask) : 32'd0;
    end
    if (ctrl.grp_emit) begin
      out_prev_mask     <= prev_r;
      out_group         <= g;
      out_field_mask    <= fld.fm;
      out_field_value   <= fld.fv;
      out_found         <= 1'b0;
      out_irq_index     <= 5'd0;
      out_is_peripheral <= 1'b0;
      out_last          <= stat.grp_last;
    end else if (ctrl.none_emit) begin
      out_prev_mask     <= prev_r;
      out_group         <= imdp_pkg::GRP_NONE;
      out_field_mask    <= 16'd0;
      out_field_value   <= 16'd0;
      out_found         <= 1'b0;
      out_irq_index     <= 5'd0;
      out_is_peripheral <= 1'b0;
      out_last          <= 1'b1;
    end else if (ctrl.disp_emit) begin
      out_prev_mask     <= 32'd0;
      out_group         <= imdp_pkg::GRP_NONE;
      out_field_mask    <= 16'd0;
      out_field_value   <= 16'd0;
      out_found         <= stat.disp_hit;
      out_irq_index     <= imdp_pkg::first_src(hit);
      out_is_peripheral <= imdp_pkg::first_src(hit) > 5'd4;
      out_last          <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_gm_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
    gm_r[4:0] == 5'd0) else $error("global mask low bits set");
  a_pi_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    pi_en_r[7:4] == 4'hF) else $error("pi enable fixed bits lost");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_found_nogrp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found) |-> (out_group == imdp_pkg::GRP_NONE && out_last))
    else $error("dispatch result malformed");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctrl.grp_emit, ctrl.none_emit, ctrl.disp_emit}) <= 1)
    else $error("multiple emits");
`endif

endmodule
`default_nettype wire

@@ rtl/interrupt_mask_and_priority_dispatch_core.sv @@
// Mask/unmask: accepted in idle, then one group scanned per cycle (up to 7),
//   one result per changed group, or one no-change result; held results stall.
// Dispatch: accepted in idle, one priority-table entry per cycle (up to 11),
//   single result, stalling on a held result. One request in flight at a time.
// Reset (rst_n low, synchronous): global mask 0xFFFFFFE0, pi enable 0xF0,
//   local mask 0, no result pending.
`default_nettype none
module interrupt_mask_and_priority_dispatch_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_mask_bits,
  input  wire logic [15:0] in_pi_status,
  input  wire logic [4:0]  in_mem_status,
  input  wire logic [15:0] in_dsp_status,
  input  wire logic [15:0] in_ai_status,
  input  wire logic [15:0] in_exi0_status,
  input  wire logic [15:0] in_exi1_status,
  input  wire logic [15:0] in_exi2_status,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_prev_mask,
  output logic [2:0]       out_group,
  output logic [15:0]      out_field_mask,
  output logic [15:0]      out_field_value,
  output logic             out_found,
  output logic [4:0]       out_irq_index,
  output logic             out_is_peripheral,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_local_mask
);

  imdp_pkg::ctrl_t ctrl;
  imdp_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  imdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  imdp_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .stat              (stat),
    .cfg_valid         (cfg_valid),
    .cfg_local_mask    (cfg_local_mask),
    .in_cmd            (in_cmd),
    .in_mask_bits      (in_mask_bits),
    .in_pi_status      (in_pi_status),
    .in_mem_status     (in_mem_status),
    .in_dsp_status     (in_dsp_status),
    .in_ai_status      (in_ai_status),
    .in_exi0_status    (in_exi0_status),
    .in_exi1_status    (in_exi1_status),
    .in_exi2_status    (in_exi2_status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_prev_mask     (out_prev_mask),
    .out_group         (out_group),
    .out_field_mask    (out_field_mask),
    .out_field_value   (out_field_value),
    .out_found         (out_found),
    .out_irq_index     (out_irq_index),
    .out_is_peripheral (out_is_peripheral),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
